### rtl/nec_tx_pkg.sv
package nec_tx_pkg;

	localparam int FRAME_BITS = 32;
	localparam int TICK_W     = 16;
	localparam int GAP_W      = 20;
	localparam int BYTE_W     = 8;
	localparam int BITPOS_W   = $clog2(FRAME_BITS + 1);
	localparam int CFG_IDX_W  = 3;

	localparam logic [GAP_W-1:0] GAP_MAX = '1;

	// phase codes
	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_HDR_MARK  = 3'd1;
	localparam logic [2:0] PH_HDR_SPACE = 3'd2;
	localparam logic [2:0] PH_BIT_MARK  = 3'd3;
	localparam logic [2:0] PH_BIT_SPACE = 3'd4;
	localparam logic [2:0] PH_STOP      = 3'd5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HDR_MARK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HDR_SPACE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_MARK = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_GAP = 3'd6;

	// register reset values
	localparam logic [TICK_W-1:0] RST_HDR_MARK   = 16'd9000;
	localparam logic [TICK_W-1:0] RST_HDR_SPACE  = 16'd4500;
	localparam logic [TICK_W-1:0] RST_BIT_MARK   = 16'd562;
	localparam logic [TICK_W-1:0] RST_ONE_SPACE  = 16'd1687;
	localparam logic [TICK_W-1:0] RST_ZERO_SPACE = 16'd562;
	localparam logic [TICK_W-1:0] RST_STOP_MARK  = 16'd562;
	localparam logic [GAP_W-1:0]  RST_FRAME_GAP  = 20'd110000;

	typedef struct packed {
		logic [TICK_W-1:0] hdr_mark;
		logic [TICK_W-1:0] hdr_space;
		logic [TICK_W-1:0] bit_mark;
		logic [TICK_W-1:0] one_space;
		logic [TICK_W-1:0] zero_space;
		logic [TICK_W-1:0] stop_mark;
	} frame_cfg_t;

	typedef struct packed {
		logic tick;   // advance the frame in flight by one tick
		logic start;  // load a new frame after the advance
	} frame_ctl_t;

	typedef struct packed {
		logic busy_adv;  // busy after the advance, before any new start
		logic busy;      // busy after this word
		logic mark;      // mark envelope after this word
	} frame_sts_t;

	// a phase length of zero acts as one
	function automatic logic [TICK_W-1:0] len_to_timer(input logic [TICK_W-1:0] len);
		len_to_timer = (len == '0) ? '0 : len - TICK_W'(1);
	endfunction

	function automatic logic [FRAME_BITS-1:0] build_word(input logic [BYTE_W-1:0] a,
		input logic [BYTE_W-1:0] c);
		build_word = {~c, c, ~a, a};
	endfunction

endpackage

### rtl/nec_tx_frame.sv
module nec_tx_frame (
	input  logic                    clk,
	input  logic                    arst_n,
	input  nec_tx_pkg::frame_cfg_t  cfg,
	input  nec_tx_pkg::frame_ctl_t  ctl,
	input  logic [7:0]              address,
	input  logic [7:0]              command,
	output nec_tx_pkg::frame_sts_t  sts
);
	import nec_tx_pkg::*;

	logic [2:0]            phase_q, phase_a, phase_n;
	logic [TICK_W-1:0]     timer_q, timer_a, timer_n;
	logic [FRAME_BITS-1:0] word_q, word_n;
	logic [BITPOS_W-1:0]   bitpos_q, bitpos_a, bitpos_n, bitpos_inc;
	logic                  busy_q, busy_a, busy_n;
	logic                  cur_bit;

	assign bitpos_inc = bitpos_q + BITPOS_W'(1);
	assign cur_bit    = word_q[bitpos_q[$clog2(FRAME_BITS)-1:0]];

	// advance the frame in flight
	always_comb begin
		phase_a  = phase_q;
		timer_a  = timer_q;
		bitpos_a = bitpos_q;
		busy_a   = busy_q;
		if (ctl.tick && busy_q) begin
			if (timer_q != '0) begin
				timer_a = timer_q - TICK_W'(1);
			end else begin
				unique case (phase_q)
					PH_HDR_MARK: begin
						phase_a = PH_HDR_SPACE;
						timer_a = len_to_timer(cfg.hdr_space);
					end
					PH_HDR_SPACE: begin
						bitpos_a = '0;
						phase_a  = PH_BIT_MARK;
						timer_a  = len_to_timer(cfg.bit_mark);
					end
					PH_BIT_MARK: begin
						phase_a = PH_BIT_SPACE;
						timer_a = len_to_timer(cur_bit ? cfg.one_space : cfg.zero_space);
					end
					PH_BIT_SPACE: begin
						bitpos_a = bitpos_inc;
						if (bitpos_inc < BITPOS_W'(FRAME_BITS)) begin
							phase_a = PH_BIT_MARK;
							timer_a = len_to_timer(cfg.bit_mark);
						end else begin
							phase_a = PH_STOP;
							timer_a = len_to_timer(cfg.stop_mark);
						end
					end
					default: begin
						busy_a  = 1'b0;
						phase_a = PH_IDLE;
						timer_a = '0;
					end
				endcase
			end
		end
	end

	// load a new frame on top of the advance
	always_comb begin
		phase_n  = phase_a;
		timer_n  = timer_a;
		bitpos_n = bitpos_a;
		busy_n   = busy_a;
		word_n   = word_q;
		if (ctl.start) begin
			word_n   = build_word(address, command);
			bitpos_n = '0;
			busy_n   = 1'b1;
			phase_n  = PH_HDR_MARK;
			timer_n  = len_to_timer(cfg.hdr_mark);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			timer_q  <= '0;
			word_q   <= '0;
			bitpos_q <= '0;
			busy_q   <= 1'b0;
		end else begin
			phase_q  <= phase_n;
			timer_q  <= timer_n;
			word_q   <= word_n;
			bitpos_q <= bitpos_n;
			busy_q   <= busy_n;
		end
	end

	assign sts.busy_adv = busy_a;
	assign sts.busy     = busy_n;
	assign sts.mark     = busy_n && (phase_n == PH_HDR_MARK || phase_n == PH_BIT_MARK ||
		phase_n == PH_STOP);

endmodule

### rtl/nec_ir_frame_transmitter.sv
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tuser opcode, s_tdata address/command/repeat_count
// m_*       out  m_tvalid/m_tready    m_tdata ir_mark/frame_busy/sequence_active/frame_started
// cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word in, one word out. Each accepted word's result is loaded into the result register;
// a new word is taken every cycle while the result register drains.
// The frame sequencer and the gap counter update in the acceptance cycle.
// arst_n clears all state but the result data bits and loads the register defaults (NEC timings).
// A stalled result holds the input side only while the result register is full
// and m_tready is low.
module nec_ir_frame_transmitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] address, [15:8] command, [23:16] repeat_count
	input  logic        s_tuser,   // [0] opcode: 0 tick, 1 start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] ir_mark, [1] frame_busy, [2] sequence_active,
	                               // [3] frame_started, [7:4] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data
);
	import nec_tx_pkg::*;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	// configuration registers
	frame_cfg_t       cfg_q;
	logic [GAP_W-1:0] gap_ticks_q;

	// sequence state
	logic [BYTE_W-1:0] seq_addr_q, seq_cmd_q, seq_rep_q, sent_q;
	logic              seq_act_q;
	logic [GAP_W-1:0]  gap_cnt_q;
	logic              gap_sat_q;

	// result register
	logic       out_vld_q;
	logic [3:0] result_q;

	logic              accept;
	logic              is_tick;
	logic [BYTE_W-1:0] in_addr, in_cmd, in_rep;
	logic [GAP_W-1:0]  gap_cnt_inc;
	logic              gap_sat_inc;
	logic              act_pre;
	logic              start_frame;
	logic [BYTE_W-1:0] sent_inc;
	frame_ctl_t        fctl;
	frame_sts_t        fsts;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = !out_vld_q || m_tready;
	assign cfg_ready = 1'b1;
	assign is_tick   = (s_tuser == OP_TICK);
	assign in_addr   = s_tdata[7:0];
	assign in_cmd    = s_tdata[15:8];
	assign in_rep    = s_tdata[23:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hdr_mark   <= RST_HDR_MARK;
			cfg_q.hdr_space  <= RST_HDR_SPACE;
			cfg_q.bit_mark   <= RST_BIT_MARK;
			cfg_q.one_space  <= RST_ONE_SPACE;
			cfg_q.zero_space <= RST_ZERO_SPACE;
			cfg_q.stop_mark  <= RST_STOP_MARK;
			gap_ticks_q      <= RST_FRAME_GAP;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HDR_MARK:   cfg_q.hdr_mark   <= cfg_data[TICK_W-1:0];
				REG_HDR_SPACE:  cfg_q.hdr_space  <= cfg_data[TICK_W-1:0];
				REG_BIT_MARK:   cfg_q.bit_mark   <= cfg_data[TICK_W-1:0];
				REG_ONE_SPACE:  cfg_q.one_space  <= cfg_data[TICK_W-1:0];
				REG_ZERO_SPACE: cfg_q.zero_space <= cfg_data[TICK_W-1:0];
				REG_STOP_MARK:  cfg_q.stop_mark  <= cfg_data[TICK_W-1:0];
				REG_FRAME_GAP:  gap_ticks_q      <= cfg_data[GAP_W-1:0];
				default: ;  // drop writes to unused indexes
			endcase
		end
	end

	// gap counter saturates; once it reaches the configured gap the next frame may go
	always_comb begin
		gap_cnt_inc = gap_cnt_q;
		gap_sat_inc = 1'b1;
		if (!gap_sat_q) begin
			if (gap_cnt_q != GAP_MAX)
				gap_cnt_inc = gap_cnt_q + GAP_W'(1);
			gap_sat_inc = (gap_cnt_inc >= gap_ticks_q);
		end
	end

	// sequence ends once the frame count reaches the repeat count
	assign act_pre     = seq_act_q && (sent_q < seq_rep_q);
	assign start_frame = accept && is_tick && act_pre && !fsts.busy_adv && gap_sat_inc;
	assign sent_inc    = sent_q + BYTE_W'(1);

	assign fctl.tick  = accept && is_tick;
	assign fctl.start = start_frame;

	nec_tx_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.ctl     (fctl),
		.address (seq_addr_q),
		.command (seq_cmd_q),
		.sts     (fsts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_addr_q <= '0;
			seq_cmd_q  <= '0;
			seq_rep_q  <= '0;
			sent_q     <= '0;
			seq_act_q  <= 1'b0;
			gap_cnt_q  <= '0;
			gap_sat_q  <= 1'b1;
		end else if (accept) begin
			if (s_tuser == OP_START) begin
				// restart the sequence; a frame in flight keeps going
				seq_addr_q <= in_addr;
				seq_cmd_q  <= in_cmd;
				seq_rep_q  <= in_rep;
				sent_q     <= '0;
				seq_act_q  <= (in_rep != '0);
				gap_sat_q  <= 1'b1;
			end else if (start_frame) begin
				gap_cnt_q <= '0;
				gap_sat_q <= (gap_ticks_q == '0);
				sent_q    <= sent_inc;
				seq_act_q <= (sent_inc < seq_rep_q);
			end else begin
				gap_cnt_q <= gap_cnt_inc;
				gap_sat_q <= gap_sat_inc;
				seq_act_q <= act_pre;
			end
		end
	end

	// result register: load on accept, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (accept) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (s_tuser == OP_START) begin
				result_q <= {1'b0, (in_rep != '0), fsts.busy, fsts.mark};
			end else if (start_frame) begin
				result_q <= {1'b1, (sent_inc < seq_rep_q), fsts.busy, fsts.mark};
			end else begin
				result_q <= {1'b0, act_pre, fsts.busy, fsts.mark};
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'b0000, result_q};

endmodule

### rtl/nec_tx_checker.sv
module nec_tx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	// a mark only shows while a frame is in flight
	a_mark_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[1])
		else $error("ir_mark without frame_busy");

	// a new frame opens with its header mark
	a_start_mark: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[0] && m_tdata[1])
		else $error("frame_started without header mark");

	// an empty result register never stalls the input
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

endmodule

bind nec_ir_frame_transmitter nec_tx_checker u_nec_tx_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### verif/nec_ir_frame_checker.sv
package nec_ir_tb_pkg;

	// kind of word on the input stream
	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_START = 1'b1
	} ir_op_e;

	// index with no register behind it
	localparam logic [2:0] REG_SPARE = 3'd7;

endpackage

module nec_ir_frame_checker
	import nec_tx_pkg::*;
	import nec_ir_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data,
	output int          mismatches,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic mark;
		logic busy;
		logic active;
		logic started;
	} envelope_t;

	// timing registers
	logic [TICK_W-1:0] hdr_mark_len, hdr_space_len, bit_mark_len;
	logic [TICK_W-1:0] one_space_len, zero_space_len, stop_mark_len;
	logic [GAP_W-1:0]  gap_len;

	// frame and sequence state
	logic [2:0]            tx_phase;
	logic [TICK_W-1:0]     phase_left;
	logic [FRAME_BITS-1:0] tx_word;
	logic [5:0]            bit_idx;
	logic                  in_flight;
	logic [7:0]            ld_addr, ld_cmd, ld_reps, frames_out;
	logic                  seq_on;
	logic [GAP_W-1:0]      gap_count;
	logic                  gap_done;

	envelope_t status_due[$];
	envelope_t want, got;
	int        mismatch_cnt;

	task automatic clear_model();
		hdr_mark_len   = RST_HDR_MARK;
		hdr_space_len  = RST_HDR_SPACE;
		bit_mark_len   = RST_BIT_MARK;
		one_space_len  = RST_ONE_SPACE;
		zero_space_len = RST_ZERO_SPACE;
		stop_mark_len  = RST_STOP_MARK;
		gap_len        = RST_FRAME_GAP;
		tx_phase   = PH_IDLE;
		phase_left = '0;
		tx_word    = '0;
		bit_idx    = '0;
		in_flight  = 1'b0;
		ld_addr    = '0;
		ld_cmd     = '0;
		ld_reps    = '0;
		frames_out = '0;
		seq_on     = 1'b0;
		gap_count  = '0;
		gap_done   = 1'b1;
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [19:0] val);
		case (idx)
			REG_HDR_MARK:   hdr_mark_len   = val[15:0];
			REG_HDR_SPACE:  hdr_space_len  = val[15:0];
			REG_BIT_MARK:   bit_mark_len   = val[15:0];
			REG_ONE_SPACE:  one_space_len  = val[15:0];
			REG_ZERO_SPACE: zero_space_len = val[15:0];
			REG_STOP_MARK:  stop_mark_len  = val[15:0];
			REG_FRAME_GAP:  gap_len        = val;
			default: ;
		endcase
	endtask

	// a length of zero behaves as one tick
	task automatic go_phase(input logic [2:0] ph, input logic [TICK_W-1:0] len);
		tx_phase   = ph;
		phase_left = (len == '0) ? '0 : len - 16'd1;
	endtask

	task automatic step_frame();
		if (in_flight) begin
			if (phase_left != '0) begin
				phase_left = phase_left - 16'd1;
			end else begin
				case (tx_phase)
					PH_HDR_MARK: go_phase(PH_HDR_SPACE, hdr_space_len);
					PH_HDR_SPACE: begin
						bit_idx = '0;
						go_phase(PH_BIT_MARK, bit_mark_len);
					end
					PH_BIT_MARK: begin
						go_phase(PH_BIT_SPACE,
							tx_word[bit_idx[4:0]] ? one_space_len : zero_space_len);
					end
					PH_BIT_SPACE: begin
						bit_idx = bit_idx + 6'd1;
						if (bit_idx < 6'(FRAME_BITS))
							go_phase(PH_BIT_MARK, bit_mark_len);
						else
							go_phase(PH_STOP, stop_mark_len);
					end
					default: begin
						in_flight  = 1'b0;
						tx_phase   = PH_IDLE;
						phase_left = '0;
					end
				endcase
			end
		end
	endtask

	task automatic next_envelope(input logic op, input logic [23:0] payload,
		output envelope_t env);
		logic started;
		started = 1'b0;
		if (op == OP_START) begin
			ld_addr    = payload[7:0];
			ld_cmd     = payload[15:8];
			ld_reps    = payload[23:16];
			frames_out = '0;
			seq_on     = (ld_reps != '0);
			gap_done   = 1'b1;
		end else begin
			if (!gap_done) begin
				if (gap_count != GAP_MAX)
					gap_count = gap_count + 20'd1;
				if (gap_count >= gap_len)
					gap_done = 1'b1;
			end
			step_frame();
			if (seq_on && frames_out >= ld_reps)
				seq_on = 1'b0;
			if (seq_on && !in_flight && gap_done) begin
				tx_word   = {~ld_cmd, ld_cmd, ~ld_addr, ld_addr};
				bit_idx   = '0;
				in_flight = 1'b1;
				go_phase(PH_HDR_MARK, hdr_mark_len);
				gap_count  = '0;
				gap_done   = (gap_len == '0);
				frames_out = frames_out + 8'd1;
				started    = 1'b1;
				if (frames_out >= ld_reps)
					seq_on = 1'b0;
			end
		end
		env.mark    = in_flight && (tx_phase == PH_HDR_MARK || tx_phase == PH_BIT_MARK ||
			tx_phase == PH_STOP);
		env.busy    = in_flight;
		env.active  = seq_on;
		env.started = started;
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%0t ns: %s expected %0h actual %0h", $time, what, exp_v, act_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
			status_due.delete();
			mismatch_cnt = 0;
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				write_register(cfg_index, cfg_data);
			// retire before predicting, so a word never meets its own expectation
			if (m_tvalid && m_tready) begin
				got.mark    = m_tdata[0];
				got.busy    = m_tdata[1];
				got.active  = m_tdata[2];
				got.started = m_tdata[3];
				if (status_due.size() == 0) begin
					flag_mismatch("result word with nothing due", 32'd0, 32'(m_tdata));
				end else begin
					want = status_due.pop_front();
					if (got.mark !== want.mark)
						flag_mismatch("ir_mark", 32'(want.mark), 32'(got.mark));
					if (got.busy !== want.busy)
						flag_mismatch("frame_busy", 32'(want.busy), 32'(got.busy));
					if (got.active !== want.active)
						flag_mismatch("sequence_active", 32'(want.active),
							32'(got.active));
					if (got.started !== want.started)
						flag_mismatch("frame_started", 32'(want.started),
							32'(got.started));
					if (m_tdata[7:4] !== 4'd0)
						flag_mismatch("padding bits", 32'd0, 32'(m_tdata[7:4]));
				end
			end
			if (s_tvalid && s_tready) begin
				next_envelope(s_tuser, s_tdata, want);
				status_due.push_back(want);
			end
			mismatches <= mismatch_cnt;
			pending    <= status_due.size();
		end
	end

endmodule

### verif/nec_ir_frame_transmitter_tb.sv
module nec_ir_frame_transmitter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nec_tx_pkg::*;
	import nec_ir_tb_pkg::*;

	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 150;
	// enough ticks to finish any frame left from the last phase and open the
	// longest header mark
	localparam int LONG_TICKS  = 160;
	// cycles with no word moving on any channel before the run is called hung
	localparam int QUIET_LIMIT = 2000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;   // [7:0] address, [15:8] command, [23:16] repeat_count
	logic        s_tuser   = 1'b0; // [0] opcode
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;          // [0] ir_mark, [1] frame_busy, [2] sequence_active,
	                               // [3] frame_started, [7:4] zero
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [19:0] cfg_data  = '0;

	int n_bad;
	int n_due;

	// drop idle gaps on one side or the other while set
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int rx_hold   = 0;
	int quiet     = 0;

	wire s_fire   = s_tvalid & s_tready;
	wire m_fire   = m_tvalid & m_tready;
	wire cfg_fire = cfg_valid & cfg_ready;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	nec_ir_frame_transmitter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	nec_ir_frame_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (n_bad),
		.pending    (n_due)
	);

	// Idle length: mostly none, often a few cycles, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(5, 30);
	endfunction

	// Repeat count of a start word: mostly short runs, with zero and the
	// maximum mixed in so a sequence can end at once or outlive the phase.
	function automatic logic [7:0] pick_repeats();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 8'd0;
		else if (r < 25)
			return 8'd255;
		else if (r < 40)
			return 8'($urandom_range(0, 255));
		else
			return 8'($urandom_range(1, 4));
	endfunction

	// Receiver: toggle m_tready between runs of ready and stalls of random
	// length; hold it high while rx_steady is set.
	always @(posedge clk) begin
		if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
		end else if (rx_steady) begin
			m_tready <= 1'b1;
		end else if (m_tready) begin
			m_tready <= 1'b0;
			rx_hold  <= idle_len();
		end else begin
			m_tready <= 1'b1;
			rx_hold  <= $urandom_range(0, 8);
		end
	end

	// Watchdog: count cycles in which no word moves on any channel.
	always @(posedge clk) begin
		if (s_fire || m_fire || cfg_fire) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("nec_ir_frame_transmitter: mismatch");
				$finish;
			end
		end
	end

	// Offer one word and hold it until accepted. tvalid stays high on return,
	// so a word that follows at once keeps it high without a second assignment
	// in the same step; every other wait lowers it first.
	task automatic send_word(input logic op, input logic [23:0] payload);
		int gap;
		gap = tx_steady ? 0 : idle_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= payload;
		do @(posedge clk); while (!s_tready);
	endtask

	// A tick carries random payload bits, which the block must ignore.
	task automatic send_tick();
		logic [23:0] junk;
		junk = 24'($urandom);
		send_word(OP_TICK, junk);
	endtask

	task automatic send_start(input logic [7:0] addr, input logic [7:0] cmd,
		input logic [7:0] reps);
		send_word(OP_START, {reps, cmd, addr});
	endtask

	// Stop offering words and wait until every expected result word has come.
	// The first edge lets the checker's pending count catch up with the last
	// accepted word.
	task automatic hold_off();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (n_due != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Write the whole timing set. The 16-bit registers get random junk in the
	// upper data bits, which must be dropped; optionally hit the spare index.
	task automatic load_timing(input logic [15:0] hm, input logic [15:0] hs,
		input logic [15:0] bm, input logic [15:0] one, input logic [15:0] zero,
		input logic [15:0] stop, input logic [19:0] gap, input bit spare);
		logic [3:0] junk;
		junk = 4'($urandom);
		write_reg(REG_HDR_MARK, {junk, hm});
		junk = 4'($urandom);
		write_reg(REG_HDR_SPACE, {junk, hs});
		junk = 4'($urandom);
		write_reg(REG_BIT_MARK, {junk, bm});
		junk = 4'($urandom);
		write_reg(REG_ONE_SPACE, {junk, one});
		junk = 4'($urandom);
		write_reg(REG_ZERO_SPACE, {junk, zero});
		junk = 4'($urandom);
		write_reg(REG_STOP_MARK, {junk, stop});
		write_reg(REG_FRAME_GAP, gap);
		if (spare)
			write_reg(REG_SPARE, 20'($urandom));
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [15:0] lens [6];
		logic [19:0] gap;
		int          kind;
		int          start_pct;
		int          pause_at;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: zero-length header mark and zero space act as one tick,
		// no gap between frames, spare register index ignored.
		load_timing(16'd0, 16'd1, 16'd1, 16'd2, 16'd0, 16'd1, 20'd0, 1'b1);
		send_tick();                                 // idle, nothing loaded
		send_start(8'hFF, 8'h00, 8'd0);              // repeat zero ends at once
		send_tick();
		send_start(8'h00, 8'hFF, 8'd1);              // single frame
		repeat (4) send_tick();
		send_start(8'hFF, 8'hFF, 8'd2);              // restart while a frame is on the air
		repeat (4) send_tick();
		send_start(8'h00, 8'h00, 8'd255);            // longest sequence
		repeat (3) send_tick();

		for (int p = 0; p < PHASES; p++) begin
			kind = p % 4;
			for (int i = 0; i < 6; i++) begin
				case (kind)
					0:       lens[i] = 16'd1;
					1:       lens[i] = 16'($urandom_range(1, 3));
					2:       lens[i] = 16'($urandom_range(0, 6));
					default: lens[i] = 16'($urandom_range(1, 2));
				endcase
			end
			case (kind)
				0:       gap = 20'd0;
				1:       gap = 20'($urandom_range(0, 150));
				2:       gap = 20'($urandom_range(60, 400));
				default: gap = GAP_MAX;
			endcase

			// Drain before touching the registers; run one phase with no idling.
			hold_off();
			tx_steady = (p == 5);
			rx_steady <= (p == 5);
			load_timing(lens[0], lens[1], lens[2], lens[3], lens[4], lens[5], gap,
				(p % 3) == 0);

			// Open with a well-formed sequence, then mostly ticks so frames run
			// to the end, with the odd restart mixed in.
			send_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(1, 4)));
			start_pct = $urandom_range(1, 4);
			pause_at  = $urandom_range(0, PHASE_WORDS - 1);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n == pause_at)
					hold_off();
				if ($urandom_range(0, 99) < start_pct)
					send_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						pick_repeats());
				else
					send_tick();
			end
		end

		// Once: longest header mark and longest gap, no idling. The frame is far
		// too long to finish here, so only its opening stretch is checked.
		hold_off();
		tx_steady = 1'b1;
		rx_steady <= 1'b1;
		load_timing(16'hFFFF, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, GAP_MAX, 1'b0);
		send_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd1);
		repeat (LONG_TICKS) send_tick();

		// Drain, let the last word settle, then give the verdict.
		hold_off();
		repeat (4) @(posedge clk);
		if (n_bad == 0 && n_due == 0)
			$display("nec_ir_frame_transmitter: match");
		else
			$display("nec_ir_frame_transmitter: mismatch");
		$finish;
	end

endmodule
